// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated by reset.
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, gated by reset.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Holds at every edge, reset included.
`define ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) (cond)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/tij_pkg.sv
// Package: widths, request/result types and cofactor tables for the inverse Jacobian unit.
package tij_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int FIELD_W     = 32;
    localparam int OUT_W       = 32;

    localparam int NUM_VTX = 4;
    localparam int NUM_TRI = 10;
    localparam int NUM_COF = 9;

    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int PROD_W = COORD_WIDTH + DIFF_W;
    localparam int COF_W  = PROD_W + 2;
    localparam int LO_W   = COF_W / 2;
    localparam int HI_W   = COF_W - LO_W;
    localparam int PL_W   = COORD_WIDTH + LO_W + 1;
    localparam int PH_W   = COORD_WIDTH + HI_W;
    localparam int DET_W  = COORD_WIDTH + COF_W + 2;
    localparam int Q_W    = OUT_W + 2;
    localparam int NUM_SH = 2 * FRAC_BITS + 1;
    localparam int REM_W  = DET_W + Q_W;

    typedef enum logic [1:0] {AX_X, AX_Y, AX_Z} axis_t;
    typedef logic [1:0] vtx_t;

    // tri(u[a],u[b],u[c], v[a],v[b],v[c]) = sum u_j * (v_next - v_prev)
    localparam axis_t TRI_U [NUM_TRI] = '{AX_Y, AX_Z, AX_X, AX_Z, AX_X,
                                          AX_Y, AX_Y, AX_Z, AX_X, AX_Z};
    localparam axis_t TRI_V [NUM_TRI] = '{AX_Z, AX_X, AX_Y, AX_Y, AX_Z,
                                          AX_X, AX_Z, AX_X, AX_Y, AX_Y};
    localparam vtx_t TRI_I [NUM_TRI][3] = '{
        '{2'd0, 2'd2, 2'd3}, '{2'd0, 2'd2, 2'd3}, '{2'd0, 2'd2, 2'd3},
        '{2'd0, 2'd1, 2'd3}, '{2'd0, 2'd1, 2'd3}, '{2'd0, 2'd1, 2'd3},
        '{2'd0, 2'd1, 2'd2}, '{2'd0, 2'd1, 2'd2}, '{2'd0, 2'd1, 2'd2},
        '{2'd1, 2'd2, 2'd3}};

    // det = x0*tri9 + x1*cof0 + x2*cof3 + x3*cof6
    localparam int DET_TRI [NUM_VTX] = '{9, 0, 3, 6};

    typedef logic signed [FIELD_W-1:0]     field_t;
    typedef logic signed [OUT_W-1:0]       grad_val_t;
    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [COF_W-1:0]       cof_t;

    typedef struct packed {
        field_t vertex0_x;
        field_t vertex1_x;
        field_t vertex2_x;
        field_t vertex3_x;
        field_t vertex0_y;
        field_t vertex1_y;
        field_t vertex2_y;
        field_t vertex3_y;
        field_t vertex0_z;
        field_t vertex1_z;
        field_t vertex2_z;
        field_t vertex3_z;
    } tet_t;

    typedef struct packed {
        grad_val_t dxi_dx;
        grad_val_t dxi_dy;
        grad_val_t dxi_dz;
        grad_val_t deta_dx;
        grad_val_t deta_dy;
        grad_val_t deta_dz;
        grad_val_t dzeta_x;
        grad_val_t dzeta_dy;
        grad_val_t dzeta_dz;
        logic      degenerate;
        logic      overflow;
    } grad_t;

    typedef struct packed {
        coord_t [NUM_VTX-1:0] x;
        cof_t   [NUM_TRI-1:0] cof;
    } cof_out_t;

    typedef struct packed {
        logic [DET_W-1:0]              dmag;
        logic                          dneg;
        logic                          degen;
        logic [NUM_COF-1:0][COF_W-1:0] cmag;
        logic [NUM_COF-1:0]            cneg;
    } det_out_t;

endpackage

// File: hw/rtl/tetrahedron_inverse_jacobian_unit.sv
// Top level of the tetrahedron inverse Jacobian unit.
// Request channel tet_valid/tet_ready/tet carries the twelve vertex coordinates
// (signed Q16.16). Result channel grad_valid/grad_ready/grad carries the nine
// gradients of xi, eta and zeta along x, y and z (signed Q16.16, saturated),
// plus degenerate (zero determinant, gradients forced to zero) and overflow.
// The unit has 41 register stages: 2 cofactor, 3 determinant, 1 range check,
// 34 divider (one quotient bit each, nine lanes in parallel) and 1 rounding
// stage. Throughput is one request per cycle while the receiver keeps up;
// every stage holds a valid bit. When the receiver stalls, the last stage
// holds its result and earlier stages keep moving until they fill, so
// bubbles are squeezed out before tet_ready drops. Reset clears all valid
// bits; no result is pending after it.
module tetrahedron_inverse_jacobian_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           tet_valid,
    output logic           tet_ready,
    input  tij_pkg::tet_t  tet,
    output logic           grad_valid,
    input  logic           grad_ready,
    output tij_pkg::grad_t grad
);
    import tij_pkg::*;

    cof_out_t cof_data;
    logic     cof_valid;
    logic     cof_ready;
    det_out_t det_data;
    logic     det_valid;
    logic     det_ready;

    tij_cofactor u_cof (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (tet_valid),
        .in_ready  (tet_ready),
        .in_data   (tet),
        .out_valid (cof_valid),
        .out_ready (cof_ready),
        .out_data  (cof_data)
    );

    tij_det u_det (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cof_valid),
        .in_ready  (cof_ready),
        .in_data   (cof_data),
        .out_valid (det_valid),
        .out_ready (det_ready),
        .out_data  (det_data)
    );

    tij_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (det_valid),
        .in_ready  (det_ready),
        .in_data   (det_data),
        .out_valid (grad_valid),
        .out_ready (grad_ready),
        .out_data  (grad)
    );

endmodule

// File: hw/rtl/tij_cofactor.sv
// Cofactor stages: edge products, then three-term cofactor sums.
module tij_cofactor (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  tij_pkg::tet_t    in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output tij_pkg::cof_out_t out_data
);
    import tij_pkg::*;

    coord_t                    c [3][NUM_VTX];
    logic signed [PROD_W-1:0]  prod_next [NUM_TRI][3];
    logic signed [PROD_W-1:0]  prod_reg  [NUM_TRI][3];
    coord_t [NUM_VTX-1:0]      x_reg;
    cof_out_t                  out_next;
    cof_out_t                  out_reg;
    logic [1:0]                v_reg;
    logic [1:0]                en;

    assign c[AX_X][0] = COORD_WIDTH'(in_data.vertex0_x);
    assign c[AX_X][1] = COORD_WIDTH'(in_data.vertex1_x);
    assign c[AX_X][2] = COORD_WIDTH'(in_data.vertex2_x);
    assign c[AX_X][3] = COORD_WIDTH'(in_data.vertex3_x);
    assign c[AX_Y][0] = COORD_WIDTH'(in_data.vertex0_y);
    assign c[AX_Y][1] = COORD_WIDTH'(in_data.vertex1_y);
    assign c[AX_Y][2] = COORD_WIDTH'(in_data.vertex2_y);
    assign c[AX_Y][3] = COORD_WIDTH'(in_data.vertex3_y);
    assign c[AX_Z][0] = COORD_WIDTH'(in_data.vertex0_z);
    assign c[AX_Z][1] = COORD_WIDTH'(in_data.vertex1_z);
    assign c[AX_Z][2] = COORD_WIDTH'(in_data.vertex2_z);
    assign c[AX_Z][3] = COORD_WIDTH'(in_data.vertex3_z);

    always_comb
    begin
        coord_t                   u;
        logic signed [DIFF_W-1:0] dif;
        for (int t = 0; t < NUM_TRI; t++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                u   = c[TRI_U[t]][TRI_I[t][j]];
                dif = DIFF_W'(c[TRI_V[t]][TRI_I[t][(j + 1) % 3]])
                    - DIFF_W'(c[TRI_V[t]][TRI_I[t][(j + 2) % 3]]);
                prod_next[t][j] = u * dif;
            end
        end
    end

    always_comb
    begin
        out_next.x = x_reg;
        for (int t = 0; t < NUM_TRI; t++)
        begin
            out_next.cof[t] = COF_W'(prod_reg[t][0]) + COF_W'(prod_reg[t][1])
                            + COF_W'(prod_reg[t][2]);
        end
    end

    assign en[1]     = !v_reg[1] || out_ready;
    assign en[0]     = !v_reg[0] || en[1];
    assign in_ready  = en[0];
    assign out_valid = v_reg[1];
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            if (en[1])
            begin
                v_reg[1] <= v_reg[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            prod_reg <= prod_next;
            x_reg    <= {c[AX_X][3], c[AX_X][2], c[AX_X][1], c[AX_X][0]};
        end
        if (en[1])
        begin
            out_reg <= out_next;
        end
    end

endmodule

// File: hw/rtl/tij_det.sv
// Determinant stages: split products, sum, then magnitudes and signs.
module tij_det (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tij_pkg::cof_out_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output tij_pkg::det_out_t out_data
);
    import tij_pkg::*;

    logic signed [PL_W-1:0]  pl_next [NUM_VTX];
    logic signed [PH_W-1:0]  ph_next [NUM_VTX];
    logic signed [PL_W-1:0]  pl_reg  [NUM_VTX];
    logic signed [PH_W-1:0]  ph_reg  [NUM_VTX];
    cof_t [NUM_COF-1:0]      cof_reg;
    logic signed [DET_W-1:0] det_next;
    logic signed [DET_W-1:0] det_reg;
    logic [NUM_COF-1:0][COF_W-1:0] cmag_next;
    logic [NUM_COF-1:0][COF_W-1:0] cmag_reg;
    logic [NUM_COF-1:0]      cneg_next;
    logic [NUM_COF-1:0]      cneg_reg;
    det_out_t                out_next;
    det_out_t                out_reg;
    logic [2:0]              v_reg;
    logic [2:0]              en;

    always_comb
    begin
        cof_t cf;
        for (int i = 0; i < NUM_VTX; i++)
        begin
            cf         = in_data.cof[DET_TRI[i]];
            pl_next[i] = $signed(in_data.x[i]) * $signed({1'b0, cf[LO_W-1:0]});
            ph_next[i] = $signed(in_data.x[i]) * $signed(cf[COF_W-1:LO_W]);
        end
    end

    always_comb
    begin
        logic signed [DET_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < NUM_VTX; i++)
        begin
            acc = acc + (DET_W'(ph_reg[i]) <<< LO_W) + DET_W'(pl_reg[i]);
        end
        det_next = acc;
        for (int k = 0; k < NUM_COF; k++)
        begin
            cneg_next[k] = cof_reg[k][COF_W-1];
            cmag_next[k] = cneg_next[k] ? COF_W'(-cof_reg[k]) : COF_W'(cof_reg[k]);
        end
    end

    always_comb
    begin
        out_next.dneg  = det_reg[DET_W-1];
        out_next.dmag  = out_next.dneg ? DET_W'(-det_reg) : DET_W'(det_reg);
        out_next.degen = (det_reg == '0);
        out_next.cmag  = cmag_reg;
        out_next.cneg  = cneg_reg;
    end

    assign en[2]     = !v_reg[2] || out_ready;
    assign en[1]     = !v_reg[1] || en[2];
    assign en[0]     = !v_reg[0] || en[1];
    assign in_ready  = en[0];
    assign out_valid = v_reg[2];
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            if (en[1])
            begin
                v_reg[1] <= v_reg[0];
            end
            if (en[2])
            begin
                v_reg[2] <= v_reg[1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            pl_reg  <= pl_next;
            ph_reg  <= ph_next;
            cof_reg <= in_data.cof[NUM_COF-1:0];
        end
        if (en[1])
        begin
            det_reg  <= det_next;
            cmag_reg <= cmag_next;
            cneg_reg <= cneg_next;
        end
        if (en[2])
        begin
            out_reg <= out_next;
        end
    end

endmodule

// File: hw/rtl/tij_divider.sv
// Pipelined restoring divider: nine lanes, one quotient bit per stage, round and saturate.
module tij_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tij_pkg::det_out_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output tij_pkg::grad_t    out_data
);
    import tij_pkg::*;

    localparam int N_ST = Q_W + 2;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [Q_W-1:0]   q;
        logic             sat;
        logic             neg;
    } lane_t;

    typedef struct packed {
        lane_t [NUM_COF-1:0] lane;
        logic [DET_W-1:0]    dmag;
        logic                degen;
    } div_st_t;

    div_st_t           st_next [Q_W+1];
    div_st_t           st_reg  [Q_W+1];
    grad_val_t         res [NUM_COF];
    logic              ov;
    grad_t             out_next;
    grad_t             out_reg;
    logic [N_ST-1:0]   v_reg;
    logic [N_ST-1:0]   en;

    always_comb
    begin
        logic [REM_W-1:0] dtop;
        dtop = REM_W'(in_data.dmag) << Q_W;
        st_next[0].dmag  = in_data.dmag;
        st_next[0].degen = in_data.degen;
        for (int k = 0; k < NUM_COF; k++)
        begin
            st_next[0].lane[k].rem = REM_W'(in_data.cmag[k]) << NUM_SH;
            st_next[0].lane[k].q   = '0;
            st_next[0].lane[k].sat = (st_next[0].lane[k].rem >= dtop);
            st_next[0].lane[k].neg = in_data.cneg[k] ^ in_data.dneg;
        end
    end

    for (genvar s = 0; s < Q_W; s++)
    begin : g_step
        always_comb
        begin
            logic [REM_W-1:0] dsh;
            st_next[s+1] = st_reg[s];
            dsh = REM_W'(st_reg[s].dmag) << (Q_W - 1 - s);
            for (int k = 0; k < NUM_COF; k++)
            begin
                if (st_reg[s].lane[k].rem >= dsh)
                begin
                    st_next[s+1].lane[k].rem        = st_reg[s].lane[k].rem - dsh;
                    st_next[s+1].lane[k].q[Q_W-1-s] = 1'b1;
                end
            end
        end
    end

    // round half away from zero on the magnitude, then clamp and apply sign
    always_comb
    begin
        logic [Q_W:0] qr;
        logic [Q_W:0] lim;
        logic [Q_W:0] mag;
        ov = 1'b0;
        for (int k = 0; k < NUM_COF; k++)
        begin
            qr  = ({1'b0, st_reg[Q_W].lane[k].q} + 1'b1) >> 1;
            lim = ((Q_W+1)'(1) << (OUT_W - 1)) - (st_reg[Q_W].lane[k].neg ? '0 : 1'b1);
            mag = qr;
            if (st_reg[Q_W].lane[k].sat || qr > lim)
            begin
                mag = lim;
                ov  = 1'b1;
            end
            res[k] = st_reg[Q_W].lane[k].neg ? OUT_W'(-mag[OUT_W-1:0]) : mag[OUT_W-1:0];
            if (st_reg[Q_W].degen)
            begin
                res[k] = '0;
            end
        end
        out_next.dxi_dx     = res[0];
        out_next.dxi_dy     = res[1];
        out_next.dxi_dz     = res[2];
        out_next.deta_dx    = res[3];
        out_next.deta_dy    = res[4];
        out_next.deta_dz    = res[5];
        out_next.dzeta_x    = res[6];
        out_next.dzeta_dy   = res[7];
        out_next.dzeta_dz   = res[8];
        out_next.degenerate = st_reg[Q_W].degen;
        out_next.overflow   = ov && !st_reg[Q_W].degen;
    end

    assign en[N_ST-1] = !v_reg[N_ST-1] || out_ready;
    for (genvar i = 0; i < N_ST - 1; i++)
    begin : g_en
        assign en[i] = !v_reg[i] || en[i+1];
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[N_ST-1];
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < N_ST; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i <= Q_W; i++)
        begin
            if (en[i])
            begin
                st_reg[i] <= st_next[i];
            end
        end
        if (en[N_ST-1])
        begin
            out_reg <= out_next;
        end
    end

endmodule

// File: hw/rtl/tij_checker.sv
// Port checker for the inverse Jacobian unit, bound to the top level.
`include "assert_macros.svh"

module tij_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           grad_valid,
    input logic           grad_ready,
    input tij_pkg::grad_t grad
);
    import tij_pkg::*;

    logic grads_zero;

    assign grads_zero = grad.dxi_dx == 0 && grad.dxi_dy == 0 && grad.dxi_dz == 0
                     && grad.deta_dx == 0 && grad.deta_dy == 0 && grad.deta_dz == 0
                     && grad.dzeta_x == 0 && grad.dzeta_dy == 0 && grad.dzeta_dz == 0;

    `ASSERT_ALWAYS(a_reset_empty, rst_n || !grad_valid)

    `ASSERT_IMPL(a_degen_zero, grad_valid && grad.degenerate, !grad.overflow && grads_zero)

    `ASSERT_NEXT(a_stall_hold, grad_valid && !grad_ready, grad_valid && $stable(grad))

endmodule

bind tetrahedron_inverse_jacobian_unit tij_checker u_chk (.*);

// File: verif/tetrahedron_inverse_jacobian_unit_tb.sv
// Testbench for the tetrahedron inverse Jacobian unit: exact gradient predictor and scoreboard.
module tetrahedron_inverse_jacobian_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tij_pkg::*;

    typedef logic signed [127:0] exact_t;
    typedef logic [127:0] umag_t;

    class grad_scoreboard;
        grad_t pending[$];
        int mismatches;
        int checked;
        int degenerate_seen;
        int overflow_seen;

        function exact_t tri_sum(exact_t ua, exact_t ub, exact_t uc,
                                 exact_t va, exact_t vb, exact_t vc);
            return ua * (vb - vc) + ub * (vc - va) + uc * (va - vb);
        endfunction

        // round(num * 2^(2F) / den), ties away from zero, saturated
        function grad_val_t scaled_quotient(exact_t num, exact_t den, ref bit sat);
            umag_t nmag;
            umag_t dmag;
            umag_t q;
            umag_t r;
            umag_t lim;
            bit neg;
            nmag = (num < 0) ? umag_t'(-num) : umag_t'(num);
            dmag = (den < 0) ? umag_t'(-den) : umag_t'(den);
            neg = (num < 0) != (den < 0);
            nmag = nmag << (2 * FRAC_BITS);
            q = nmag / dmag;
            r = nmag % dmag;
            if ((r << 1) >= dmag)
                q = q + 1;
            lim = neg ? umag_t'(128'h8000_0000) : umag_t'(128'h7FFF_FFFF);
            if (q > lim)
            begin
                sat = 1'b1;
                q = lim;
            end
            if (neg)
                q = -q;
            return grad_val_t'(q[31:0]);
        endfunction

        function void note_request(tet_t t);
            exact_t x[4];
            exact_t y[4];
            exact_t z[4];
            exact_t cof[9];
            exact_t det;
            grad_t g;
            bit sat;
            x[0] = t.vertex0_x; x[1] = t.vertex1_x; x[2] = t.vertex2_x; x[3] = t.vertex3_x;
            y[0] = t.vertex0_y; y[1] = t.vertex1_y; y[2] = t.vertex2_y; y[3] = t.vertex3_y;
            z[0] = t.vertex0_z; z[1] = t.vertex1_z; z[2] = t.vertex2_z; z[3] = t.vertex3_z;
            cof[0] = tri_sum(y[0], y[2], y[3], z[0], z[2], z[3]);
            cof[1] = tri_sum(z[0], z[2], z[3], x[0], x[2], x[3]);
            cof[2] = tri_sum(x[0], x[2], x[3], y[0], y[2], y[3]);
            cof[3] = tri_sum(z[0], z[1], z[3], y[0], y[1], y[3]);
            cof[4] = tri_sum(x[0], x[1], x[3], z[0], z[1], z[3]);
            cof[5] = tri_sum(y[0], y[1], y[3], x[0], x[1], x[3]);
            cof[6] = tri_sum(y[0], y[1], y[2], z[0], z[1], z[2]);
            cof[7] = tri_sum(z[0], z[1], z[2], x[0], x[1], x[2]);
            cof[8] = tri_sum(x[0], x[1], x[2], y[0], y[1], y[2]);
            det = x[0] * tri_sum(z[1], z[2], z[3], y[1], y[2], y[3])
                + x[1] * cof[0] + x[2] * cof[3] + x[3] * cof[6];
            g = '0;
            sat = 1'b0;
            if (det == 0)
                g.degenerate = 1'b1;
            else
            begin
                g.dxi_dx   = scaled_quotient(cof[0], det, sat);
                g.dxi_dy   = scaled_quotient(cof[1], det, sat);
                g.dxi_dz   = scaled_quotient(cof[2], det, sat);
                g.deta_dx  = scaled_quotient(cof[3], det, sat);
                g.deta_dy  = scaled_quotient(cof[4], det, sat);
                g.deta_dz  = scaled_quotient(cof[5], det, sat);
                g.dzeta_x  = scaled_quotient(cof[6], det, sat);
                g.dzeta_dy = scaled_quotient(cof[7], det, sat);
                g.dzeta_dz = scaled_quotient(cof[8], det, sat);
                g.overflow = sat;
            end
            pending.push_back(g);
        endfunction

        function void check_result(grad_t got);
            grad_t exp_g;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
                return;
            end
            exp_g = pending.pop_front();
            checked++;
            if (exp_g.degenerate)
                degenerate_seen++;
            if (exp_g.overflow)
                overflow_seen++;
            if (got !== exp_g)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch #%0d at %0t", checked, $realtime);
                    $display("  exp dxi %0d %0d %0d deta %0d %0d %0d",
                             exp_g.dxi_dx, exp_g.dxi_dy, exp_g.dxi_dz,
                             exp_g.deta_dx, exp_g.deta_dy, exp_g.deta_dz);
                    $display("  exp dzeta %0d %0d %0d deg %b ovf %b",
                             exp_g.dzeta_x, exp_g.dzeta_dy, exp_g.dzeta_dz,
                             exp_g.degenerate, exp_g.overflow);
                    $display("  got dxi %0d %0d %0d deta %0d %0d %0d",
                             got.dxi_dx, got.dxi_dy, got.dxi_dz,
                             got.deta_dx, got.deta_dy, got.deta_dz);
                    $display("  got dzeta %0d %0d %0d deg %b ovf %b",
                             got.dzeta_x, got.dzeta_dy, got.dzeta_dz,
                             got.degenerate, got.overflow);
                end
            end
        endfunction
    endclass

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 60;

    logic clk;
    logic rst_n;
    logic tet_valid;
    logic tet_ready;
    tet_t tet;
    logic grad_valid;
    logic grad_ready;
    grad_t grad;

    grad_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int sent;
    int stall_cycles;

    tetrahedron_inverse_jacobian_unit u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .tet_valid  (tet_valid),
        .tet_ready  (tet_ready),
        .tet        (tet),
        .grad_valid (grad_valid),
        .grad_ready (grad_ready),
        .grad       (grad)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(negedge clk)
        grad_ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && grad_valid && grad_ready)
            sb.check_result(grad);
        if ((tet_valid && tet_ready) || (grad_valid && grad_ready) || !rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_request(tet_t t);
        while ($urandom_range(99) < send_idle_pct)
        begin
            tet_valid = 1'b0;
            @(negedge clk);
        end
        tet_valid = 1'b1;
        tet = t;
        do
            @(posedge clk);
        while (!tet_ready);
        sb.note_request(t);
        sent++;
        @(negedge clk);
    endtask

    function automatic field_t coord_in(int kind);
        case (kind)
            0: return field_t'($urandom_range(8191)) - 4096 <<< 8;
            1: return field_t'($urandom());
            2: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return field_t'($urandom_range(200000)) - 100000;
        endcase
    endfunction

    function automatic tet_t random_tet();
        tet_t t;
        int kind;
        int shape;
        kind = $urandom_range(9);
        shape = $urandom_range(9);
        if (kind < 6)
            kind = 3;
        else if (kind < 8)
            kind = 0;
        else if (kind == 8)
            kind = 1;
        else
            kind = 2;
        t.vertex0_x = coord_in(kind); t.vertex1_x = coord_in(kind);
        t.vertex2_x = coord_in(kind); t.vertex3_x = coord_in(kind);
        t.vertex0_y = coord_in(kind); t.vertex1_y = coord_in(kind);
        t.vertex2_y = coord_in(kind); t.vertex3_y = coord_in(kind);
        t.vertex0_z = coord_in(kind); t.vertex1_z = coord_in(kind);
        t.vertex2_z = coord_in(kind); t.vertex3_z = coord_in(kind);
        // coplanar: one vertex repeated
        if (shape == 0)
        begin
            t.vertex3_x = t.vertex1_x; t.vertex3_y = t.vertex1_y; t.vertex3_z = t.vertex1_z;
        end
        // sliver: vertices one or two LSBs apart (coplanar when the z offset is 0), gradients saturate
        else if (shape == 1)
        begin
            t.vertex1_x = t.vertex0_x + 1; t.vertex1_y = t.vertex0_y;
            t.vertex1_z = t.vertex0_z;
            t.vertex2_x = t.vertex0_x; t.vertex2_y = t.vertex0_y + 1;
            t.vertex2_z = t.vertex0_z;
            t.vertex3_x = t.vertex0_x; t.vertex3_y = t.vertex0_y;
            t.vertex3_z = t.vertex0_z + field_t'($urandom_range(3)) - 1;
        end
        return t;
    endfunction

    function automatic tet_t ref_tet(field_t h, bit flip);
        tet_t t;
        t = '0;
        t.vertex1_x = h;
        t.vertex2_y = h;
        t.vertex3_z = flip ? -h : h;
        return t;
    endfunction

    initial
    begin
        tet_t t;
        sb = new();
        rst_n = 1'b0;
        tet_valid = 1'b0;
        tet = '0;
        send_idle_pct = 18;
        recv_idle_pct = 54;
        sent = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: all zero, unit and scaled elements, mirrored, slivers, extremes
        send_request('0);
        send_request(ref_tet(32'sh0001_0000, 1'b0));
        send_request(ref_tet(32'sh0001_0000, 1'b1));
        send_request(ref_tet(32'sh0002_0000, 1'b0));
        send_request(ref_tet(32'sh0000_0001, 1'b0));
        send_request(ref_tet(32'sh0000_0003, 1'b1));
        send_request(ref_tet(32'sh7FFF_FFFF, 1'b0));
        send_request(ref_tet(32'sh8000_0000, 1'b0));
        send_request(ref_tet(32'sh0000_8000, 1'b1));
        send_request({12{32'sh7FFF_FFFF}});
        send_request({12{32'sh8000_0000}});
        t = ref_tet(32'sh8000_0000, 1'b0);
        t.vertex0_x = 32'sh7FFF_FFFF; t.vertex0_y = 32'sh7FFF_FFFF;
        t.vertex0_z = 32'sh7FFF_FFFF;
        send_request(t);
        t = ref_tet(32'sh7FFF_FFFF, 1'b1);
        t.vertex0_x = 32'sh8000_0000; t.vertex0_y = 32'sh8000_0000;
        send_request(t);
        t = ref_tet(32'sh0003_0000, 1'b0);
        t.vertex1_y = 32'sh0001_0000; t.vertex2_z = 32'sh0002_0000;
        t.vertex3_x = 32'shFFFF_0000;
        send_request(t);
        repeat (8) send_request(random_tet());

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 54 : 0;
            recv_idle_pct = (phase == 0) ? 54 : (phase == 1) ? 18 : 0;
            repeat (210) send_request(random_tet());
        end
        tet_valid = 1'b0;
        recv_idle_pct = 0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d tetrahedra sent, %0d results checked", sent, sb.checked);
        $display("%0d degenerate, %0d saturated, %0d mismatches",
                 sb.degenerate_seen, sb.overflow_seen, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
